// ===== sv/qpmm_pkg.sv =====
`default_nettype none

package qpmm_pkg;

   // Sample command codes carried in the input tuser
   typedef enum logic [1:0] {
      CMD_NONE   = 2'd0,
      CMD_STOP   = 2'd1,
      CMD_DISARM = 2'd2,
      CMD_ARM    = 2'd3
   } cmd_type;

   // Gain register indexes on the configuration channel
   localparam logic [2:0] REG_PITCH_P = 3'd0;
   localparam logic [2:0] REG_PITCH_I = 3'd1;
   localparam logic [2:0] REG_PITCH_D = 3'd2;
   localparam logic [2:0] REG_ROLL_P  = 3'd3;
   localparam logic [2:0] REG_ROLL_I  = 3'd4;
   localparam logic [2:0] REG_ROLL_D  = 3'd5;
   localparam logic [2:0] REG_YAW_P   = 3'd6;
   localparam logic [2:0] REG_YAW_I   = 3'd7;

   // Gain values after reset
   localparam logic [15:0] RST_PITCH_P = 16'd10;
   localparam logic [31:0] RST_PITCH_I = 32'd16777;
   localparam logic [15:0] RST_PITCH_D = 16'd950;
   localparam logic [15:0] RST_ROLL_P  = 16'd10;
   localparam logic [31:0] RST_ROLL_I  = 32'd83886;
   localparam logic [15:0] RST_ROLL_D  = 16'd1050;
   localparam logic [15:0] RST_YAW_P   = 16'd200;
   localparam logic [31:0] RST_YAW_I   = 32'd167772160;

   // Product issued to the shared multiplier in one step
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_YAW_I,
      MUL_ROLL_I,
      MUL_YAW_OUT,
      MUL_PITCH_I,
      MUL_YAW_P,
      MUL_PITCH_D,
      MUL_PITCH_P,
      MUL_ROLL_D,
      MUL_ROLL_P
   } mul_sel_type;

   // Motor order in the mixer and in the result
   localparam logic [1:0] MOTOR_FRONT = 2'd0;
   localparam logic [1:0] MOTOR_BACK  = 2'd1;
   localparam logic [1:0] MOTOR_LEFT  = 2'd2;
   localparam logic [1:0] MOTOR_RIGHT = 2'd3;

   // Sequencer step plan
   localparam logic [3:0] STEP_YAW_I   = 4'd0;
   localparam logic [3:0] STEP_ROLL_I  = 4'd1;
   localparam logic [3:0] STEP_YAW_OUT = 4'd2;
   localparam logic [3:0] STEP_PITCH_I = 4'd3;
   localparam logic [3:0] STEP_YAW_P   = 4'd4;
   localparam logic [3:0] STEP_PITCH_D = 4'd5;
   localparam logic [3:0] STEP_PITCH_P = 4'd6;
   localparam logic [3:0] STEP_ROLL_D  = 4'd7;
   localparam logic [3:0] STEP_ROLL_P  = 4'd8;
   localparam logic [3:0] MIX_FIRST    = 4'd10;
   localparam logic [3:0] MIX_LAST     = 4'd13;
   localparam logic [3:0] STEP_LAST    = 4'd14;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic        capture;
      mul_sel_type mul_sel;
      logic        mix_en;
      logic [1:0]  mix_idx;
      logic        commit;
      logic        load_out;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic halted;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== sv/qpmm_ctrl.sv =====
`default_nettype none

module qpmm_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire qpmm_pkg::dp_status_type status,
   output qpmm_pkg::dp_cmd_type        cmd
);

   qpmm_pkg::state_type state_ff, state_in;
   logic [3:0]          step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_busy;

   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign req_tready = (state_ff == qpmm_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and step count
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         qpmm_pkg::ST_IDLE: begin
            step_in = '0;
            if (req_tvalid) begin
               // A halted block skips the computation and reports idle pulses.
               state_in = status.halted ? qpmm_pkg::ST_HOLD : qpmm_pkg::ST_RUN;
            end
         end
         qpmm_pkg::ST_RUN: begin
            step_in = step_ff + 4'd1;
            if (step_ff == qpmm_pkg::STEP_LAST) begin
               state_in = qpmm_pkg::ST_HOLD;
            end
         end
         qpmm_pkg::ST_HOLD: begin
            if (!out_busy) begin
               state_in = qpmm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = qpmm_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd = '0;
      cmd.mul_sel = qpmm_pkg::MUL_NONE;
      case (state_ff)
         qpmm_pkg::ST_IDLE: begin
            cmd.capture = req_tvalid;
         end
         qpmm_pkg::ST_RUN: begin
            case (step_ff)
               qpmm_pkg::STEP_YAW_I:   cmd.mul_sel = qpmm_pkg::MUL_YAW_I;
               qpmm_pkg::STEP_ROLL_I:  cmd.mul_sel = qpmm_pkg::MUL_ROLL_I;
               qpmm_pkg::STEP_YAW_OUT: cmd.mul_sel = qpmm_pkg::MUL_YAW_OUT;
               qpmm_pkg::STEP_PITCH_I: cmd.mul_sel = qpmm_pkg::MUL_PITCH_I;
               qpmm_pkg::STEP_YAW_P:   cmd.mul_sel = qpmm_pkg::MUL_YAW_P;
               qpmm_pkg::STEP_PITCH_D: cmd.mul_sel = qpmm_pkg::MUL_PITCH_D;
               qpmm_pkg::STEP_PITCH_P: cmd.mul_sel = qpmm_pkg::MUL_PITCH_P;
               qpmm_pkg::STEP_ROLL_D:  cmd.mul_sel = qpmm_pkg::MUL_ROLL_D;
               qpmm_pkg::STEP_ROLL_P:  cmd.mul_sel = qpmm_pkg::MUL_ROLL_P;
               default:                cmd.mul_sel = qpmm_pkg::MUL_NONE;
            endcase
            cmd.mix_en  = step_ff inside {[qpmm_pkg::MIX_FIRST:qpmm_pkg::MIX_LAST]};
            cmd.mix_idx = 2'(step_ff - qpmm_pkg::MIX_FIRST);
            cmd.commit  = (step_ff == qpmm_pkg::STEP_LAST);
         end
         qpmm_pkg::ST_HOLD: begin
            cmd.load_out = !out_busy;
         end
         default: begin
            cmd.capture = 1'b0;
         end
      endcase
   end

   // Result valid: set on load, cleared by a transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qpmm_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/qpmm_datapath.sv =====
`default_nettype none

module qpmm_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [111:0]         req_tdata,
   input  wire logic [1:0]           req_tuser,
   output logic      [47:0]          rsp_tdata,
   output logic      [1:0]           rsp_tuser,
   input  wire logic                 csr_write,
   input  wire logic [2:0]           csr_index,
   input  wire logic [31:0]          csr_data,
   input  wire qpmm_pkg::dp_cmd_type cmd,
   output qpmm_pkg::dp_status_type   status
);

   localparam logic signed [41:0] INT_LIM     = 42'sd1677721600;
   localparam logic signed [41:0] INT_LIM_NEG = -42'sd1677721600;
   localparam logic signed [15:0] TILT_POS    = 16'sd17920;
   localparam logic signed [15:0] TILT_NEG    = -16'sd17920;
   localparam logic signed [31:0] PULSE_TOP   = 32'sd1700;
   localparam logic signed [31:0] PULSE_IDLE  = 32'sd1000;
   localparam logic [55:0]        TRUNC_BIAS  = 56'd16777215;

   // Integral step: add the scaled product, then clamp to +-100 degrees
   function automatic logic signed [31:0] int_step(input logic signed [31:0] acc,
                                                  input logic signed [63:0] prod);
      logic signed [41:0] s;
      s = {{10{acc[31]}}, acc} + prod[49:8];
      if (s > INT_LIM) begin
         s = INT_LIM;
      end else if (s < INT_LIM_NEG) begin
         s = INT_LIM_NEG;
      end
      return s[31:0];
   endfunction

   // Gain registers
   logic [15:0] pitch_p_ff, pitch_d_ff, roll_p_ff, roll_d_ff, yaw_p_ff;
   logic [31:0] pitch_i_ff, roll_i_ff, yaw_i_ff;

   // Captured sample
   logic [1:0]         command_ff;
   logic [10:0]        thrust_ff;
   logic signed [15:0] roll_tgt_ff, pitch_tgt_ff, yaw_tgt_ff;
   logic signed [15:0] roll_meas_ff, pitch_meas_ff, yaw_meas_ff;

   // Controller state
   logic signed [31:0] roll_int_ff, pitch_int_ff, yaw_int_ff;
   logic signed [15:0] last_roll_ff, last_pitch_ff;
   logic               armed_ff, halted_ff, armed_in, halted_in;

   // Multiplier and accumulators
   logic signed [16:0] roll_dev, pitch_dev, yaw_dev, d_roll, d_pitch;
   logic signed [32:0] mul_a;
   logic [31:0]        mul_b;
   logic signed [65:0] mul_full;
   logic signed [63:0] prod_ff;
   qpmm_pkg::mul_sel_type tag_ff;
   logic signed [55:0] p_term, yaw_t_ff, pitch_t_ff, roll_t_ff;

   // Mixer and pulse conversion
   logic signed [55:0] base, sum_in, sum_ff, sum_adj;
   logic               sum_valid_ff;
   logic [1:0]         sum_idx_ff;
   logic signed [31:0] us;
   logic [10:0]        pulse_in;
   logic [10:0]        pulse_ff [4];
   logic               tilt;
   logic [47:0]        out_data_ff;
   logic [1:0]         out_flags_ff;

   assign status.halted = halted_ff;
   assign rsp_tdata     = out_data_ff;
   assign rsp_tuser     = out_flags_ff;

   // Errors on the measurement and changes since the last sample
   assign roll_dev  = {roll_meas_ff[15], roll_meas_ff} - {roll_tgt_ff[15], roll_tgt_ff};
   assign pitch_dev = {pitch_meas_ff[15], pitch_meas_ff} - {pitch_tgt_ff[15], pitch_tgt_ff};
   assign yaw_dev   = {yaw_meas_ff[15], yaw_meas_ff} - {yaw_tgt_ff[15], yaw_tgt_ff};
   assign d_roll    = {roll_meas_ff[15], roll_meas_ff} - {last_roll_ff[15], last_roll_ff};
   assign d_pitch   = {pitch_meas_ff[15], pitch_meas_ff} - {last_pitch_ff[15], last_pitch_ff};

   // Gain configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_p_ff <= qpmm_pkg::RST_PITCH_P;
         pitch_i_ff <= qpmm_pkg::RST_PITCH_I;
         pitch_d_ff <= qpmm_pkg::RST_PITCH_D;
         roll_p_ff  <= qpmm_pkg::RST_ROLL_P;
         roll_i_ff  <= qpmm_pkg::RST_ROLL_I;
         roll_d_ff  <= qpmm_pkg::RST_ROLL_D;
         yaw_p_ff   <= qpmm_pkg::RST_YAW_P;
         yaw_i_ff   <= qpmm_pkg::RST_YAW_I;
      end else if (csr_write) begin
         case (csr_index)
            qpmm_pkg::REG_PITCH_P: pitch_p_ff <= csr_data[15:0];
            qpmm_pkg::REG_PITCH_I: pitch_i_ff <= csr_data;
            qpmm_pkg::REG_PITCH_D: pitch_d_ff <= csr_data[15:0];
            qpmm_pkg::REG_ROLL_P:  roll_p_ff  <= csr_data[15:0];
            qpmm_pkg::REG_ROLL_I:  roll_i_ff  <= csr_data;
            qpmm_pkg::REG_ROLL_D:  roll_d_ff  <= csr_data[15:0];
            qpmm_pkg::REG_YAW_P:   yaw_p_ff   <= csr_data[15:0];
            qpmm_pkg::REG_YAW_I:   yaw_i_ff   <= csr_data;
            default:               yaw_i_ff   <= yaw_i_ff;
         endcase
      end
   end

   // Sample capture on an input transfer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         command_ff    <= req_tuser;
         thrust_ff     <= req_tdata[10:0];
         roll_tgt_ff   <= req_tdata[26:11];
         pitch_tgt_ff  <= req_tdata[42:27];
         yaw_tgt_ff    <= req_tdata[58:43];
         roll_meas_ff  <= req_tdata[74:59];
         pitch_meas_ff <= req_tdata[90:75];
         yaw_meas_ff   <= req_tdata[106:91];
      end
   end

   // Operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         qpmm_pkg::MUL_YAW_I: begin
            mul_a = {{16{yaw_dev[16]}}, yaw_dev};
            mul_b = yaw_i_ff;
         end
         qpmm_pkg::MUL_ROLL_I: begin
            mul_a = {{16{roll_dev[16]}}, roll_dev};
            mul_b = roll_i_ff;
         end
         qpmm_pkg::MUL_YAW_OUT: begin
            mul_a = {yaw_int_ff[31], yaw_int_ff};
            mul_b = yaw_i_ff;
         end
         qpmm_pkg::MUL_PITCH_I: begin
            mul_a = {{16{pitch_dev[16]}}, pitch_dev};
            mul_b = pitch_i_ff;
         end
         qpmm_pkg::MUL_YAW_P: begin
            mul_a = {{16{yaw_dev[16]}}, yaw_dev};
            mul_b = {16'd0, yaw_p_ff};
         end
         qpmm_pkg::MUL_PITCH_D: begin
            mul_a = {{16{d_pitch[16]}}, d_pitch};
            mul_b = {16'd0, pitch_d_ff};
         end
         qpmm_pkg::MUL_PITCH_P: begin
            mul_a = {{16{pitch_dev[16]}}, pitch_dev};
            mul_b = {16'd0, pitch_p_ff};
         end
         qpmm_pkg::MUL_ROLL_D: begin
            mul_a = {{16{d_roll[16]}}, d_roll};
            mul_b = {16'd0, roll_d_ff};
         end
         qpmm_pkg::MUL_ROLL_P: begin
            mul_a = {{16{roll_dev[16]}}, roll_dev};
            mul_b = {16'd0, roll_p_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * $signed({1'b0, mul_b});

   // Product register, tagged with the product it holds
   always_ff @(posedge clock) begin
      prod_ff <= mul_full[63:0];
      if (reset) begin
         tag_ff <= qpmm_pkg::MUL_NONE;
      end else begin
         tag_ff <= cmd.mul_sel;
      end
   end

   // P and D terms enter the mixer scaled to Q.24
   assign p_term = {prod_ff[39:0], 16'd0};

   // Accumulate the registered product into its target
   always_ff @(posedge clock) begin
      if (reset) begin
         roll_int_ff  <= '0;
         pitch_int_ff <= '0;
         yaw_int_ff   <= '0;
      end else begin
         case (tag_ff)
            qpmm_pkg::MUL_YAW_I:   yaw_int_ff   <= int_step(yaw_int_ff, prod_ff);
            qpmm_pkg::MUL_ROLL_I:  roll_int_ff  <= int_step(roll_int_ff, prod_ff);
            qpmm_pkg::MUL_PITCH_I: pitch_int_ff <= int_step(pitch_int_ff, prod_ff);
            qpmm_pkg::MUL_YAW_OUT: yaw_t_ff     <= {{16{prod_ff[63]}}, prod_ff[63:24]};
            qpmm_pkg::MUL_YAW_P:   yaw_t_ff     <= yaw_t_ff + p_term;
            qpmm_pkg::MUL_PITCH_D: pitch_t_ff   <= {{24{pitch_int_ff[31]}}, pitch_int_ff} + p_term;
            qpmm_pkg::MUL_PITCH_P: pitch_t_ff   <= pitch_t_ff + p_term;
            qpmm_pkg::MUL_ROLL_D:  roll_t_ff    <= {{24{roll_int_ff[31]}}, roll_int_ff} + p_term;
            qpmm_pkg::MUL_ROLL_P:  roll_t_ff    <= roll_t_ff + p_term;
            default:               yaw_t_ff     <= yaw_t_ff;
         endcase
      end
   end

   // Mixer: one motor sum per step
   assign base = {21'd0, thrust_ff, 24'd0};

   always_comb begin
      case (cmd.mix_idx)
         qpmm_pkg::MOTOR_FRONT: sum_in = base - yaw_t_ff - pitch_t_ff;
         qpmm_pkg::MOTOR_BACK:  sum_in = base - yaw_t_ff + pitch_t_ff;
         qpmm_pkg::MOTOR_LEFT:  sum_in = base + yaw_t_ff - roll_t_ff;
         qpmm_pkg::MOTOR_RIGHT: sum_in = base + yaw_t_ff + roll_t_ff;
         default:               sum_in = base;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mix_en) begin
         sum_ff     <= sum_in;
         sum_idx_ff <= cmd.mix_idx;
      end
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= cmd.mix_en;
      end
   end

   // Truncate toward zero to whole microseconds, then clamp
   assign sum_adj = sum_ff + (sum_ff[55] ? TRUNC_BIAS : 56'd0);
   assign us      = sum_adj[55:24];

   always_comb begin
      if (us > PULSE_TOP) begin
         pulse_in = PULSE_TOP[10:0];
      end else if (us < PULSE_IDLE) begin
         pulse_in = PULSE_IDLE[10:0];
      end else begin
         pulse_in = us[10:0];
      end
   end

   always_ff @(posedge clock) begin
      if (sum_valid_ff) begin
         pulse_ff[sum_idx_ff] <= pulse_in;
      end
   end

   // Command and tilt fault applied at the end of a computed sample
   assign tilt = (roll_meas_ff > TILT_POS) || (roll_meas_ff < TILT_NEG) ||
                 (pitch_meas_ff > TILT_POS) || (pitch_meas_ff < TILT_NEG);

   always_comb begin
      halted_in = halted_ff || tilt || (command_ff == qpmm_pkg::CMD_STOP);
      armed_in  = armed_ff;
      case (command_ff)
         qpmm_pkg::CMD_DISARM: armed_in = 1'b0;
         qpmm_pkg::CMD_ARM:    armed_in = 1'b1;
         default:              armed_in = armed_ff;
      endcase
      if (halted_in) begin
         armed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff      <= 1'b0;
         halted_ff     <= 1'b0;
         last_roll_ff  <= '0;
         last_pitch_ff <= '0;
      end else if (cmd.commit) begin
         armed_ff      <= armed_in;
         halted_ff     <= halted_in;
         last_roll_ff  <= roll_meas_ff;
         last_pitch_ff <= pitch_meas_ff;
      end
   end

   // Result register; pulses idle unless armed
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (armed_ff) begin
            out_data_ff <= {4'd0, pulse_ff[qpmm_pkg::MOTOR_RIGHT],
                            pulse_ff[qpmm_pkg::MOTOR_LEFT],
                            pulse_ff[qpmm_pkg::MOTOR_BACK],
                            pulse_ff[qpmm_pkg::MOTOR_FRONT]};
         end else begin
            out_data_ff <= {4'd0, PULSE_IDLE[10:0], PULSE_IDLE[10:0],
                            PULSE_IDLE[10:0], PULSE_IDLE[10:0]};
         end
         out_flags_ff <= {halted_ff, armed_ff};
      end
   end

endmodule

`default_nettype wire

// ===== sv/quadrotor_pid_motor_mixer.sv =====
// Channel   Direction  Handshake               Payload
// req       in         req_tvalid/req_tready   req_tdata, req_tuser (command)
// rsp       out        rsp_tvalid/rsp_tready   rsp_tdata (pulses), rsp_tuser (flags)
// csr       in         csr_valid/csr_ready     csr_index, csr_data
//
// For each input transfer, nine products share one 33 by 33 bit multiplier, then
// four mixer sums are converted to pulses and the result is loaded. The next
// transfer is taken the cycle after; a halted block skips the computation.
// Reset restores the default gains and clears the integrals and flags.
// A result waiting on rsp does not block the next input transfer; a new result
// waits only if the previous one has not been taken yet.
`default_nettype none

module quadrotor_pid_motor_mixer (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // thrust_us, roll_target, pitch_target, yaw_rate_target,
   // roll_measured, pitch_measured, yaw_rate_measured, 5 zero bits
   input  wire logic [111:0] req_tdata,
   // command
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // motor_pitch_front, motor_pitch_back, motor_roll_left,
   // motor_roll_right, 4 zero bits
   output logic      [47:0]  rsp_tdata,
   // is_armed, is_halted
   output logic      [1:0]   rsp_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   qpmm_pkg::dp_cmd_type    cmd;
   qpmm_pkg::dp_status_type status;
   logic                    csr_write;

   // Gain writes are always taken.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   qpmm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   qpmm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam int CLK_HALF        = 4;
   localparam int RESET_CYCLES    = 2;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int TAIL_CYCLES     = 40;
   localparam int FLIGHT_PHASES   = 12;
   localparam int FLIGHT_SAMPLES  = 150;
   localparam int HALTED_SAMPLES  = 20;
   localparam int TILT_Q88        = 70 * 256;
   localparam longint INTEGRAL_LIMIT = 64'sd100 <<< 24;
   localparam longint PULSE_MIN   = 1000;
   localparam longint PULSE_MAX   = 1700;
   localparam logic [10:0] IDLE_PULSE = 11'd1000;

   // One control sample as it enters the block
   typedef struct packed {
      qpmm_pkg::cmd_type cmd;
      logic [10:0] thrust;
      logic [15:0] roll_tgt;
      logic [15:0] pitch_tgt;
      logic [15:0] yaw_tgt;
      logic [15:0] roll_meas;
      logic [15:0] pitch_meas;
      logic [15:0] yaw_meas;
   } sample_type;

   // Four motor pulses, indexed by the package motor order, and the flags
   typedef struct packed {
      logic             halted;
      logic             armed;
      logic [3:0][10:0] pulse;
   } motor_out_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [111:0]  req_tdata = '0;
   logic [1:0]    req_tuser = qpmm_pkg::CMD_NONE;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [47:0]   rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [2:0]    csr_index = '0;
   logic [31:0]   csr_data = '0;

   // Controller state as the testbench sees it
   longint gain [8];
   longint roll_isum = 0;
   longint pitch_isum = 0;
   longint yaw_isum = 0;
   longint prev_roll = 0;
   longint prev_pitch = 0;
   bit     armed = 1'b0;
   bit     halted = 1'b0;

   motor_out_type expected_pulses [$];
   string      motor_name [4] = '{"motor_pitch_front", "motor_pitch_back",
                                  "motor_roll_left", "motor_roll_right"};
   string      halt_cause = "nothing";
   int         fail_count = 0;
   int         sample_count = 0;
   int         armed_count = 0;
   int         setting_count = 0;
   int         burst_left = 0;
   int         idle_cycles = 0;
   int         ready_mode = 0;
   int         ready_left = 0;

   quadrotor_pid_motor_mixer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #CLK_HALF clock = ~clock;

   function automatic logic [31:0] default_gain(input int r);
      case (r)
         qpmm_pkg::REG_PITCH_P: return 32'(qpmm_pkg::RST_PITCH_P);
         qpmm_pkg::REG_PITCH_I: return qpmm_pkg::RST_PITCH_I;
         qpmm_pkg::REG_PITCH_D: return 32'(qpmm_pkg::RST_PITCH_D);
         qpmm_pkg::REG_ROLL_P:  return 32'(qpmm_pkg::RST_ROLL_P);
         qpmm_pkg::REG_ROLL_I:  return qpmm_pkg::RST_ROLL_I;
         qpmm_pkg::REG_ROLL_D:  return 32'(qpmm_pkg::RST_ROLL_D);
         qpmm_pkg::REG_YAW_P:   return 32'(qpmm_pkg::RST_YAW_P);
         default:               return qpmm_pkg::RST_YAW_I;
      endcase
   endfunction

   // Error integral step in Q8.24, rounded toward minus infinity, then clamped.
   function automatic longint integrate(input longint acc, input longint g,
                                        input longint err);
      longint sum;
      sum = acc + ((g * err) >>> 8);
      if (sum > INTEGRAL_LIMIT) sum = INTEGRAL_LIMIT;
      if (sum < -INTEGRAL_LIMIT) sum = -INTEGRAL_LIMIT;
      return sum;
   endfunction

   // Q.24 mix sum to whole microseconds within the motor range. Flooring only
   // differs from truncation below zero, where the low clamp wins anyway.
   function automatic logic [10:0] to_pulse(input longint q24);
      longint us;
      us = q24 >>> 24;
      if (us > PULSE_MAX) us = PULSE_MAX;
      if (us < PULSE_MIN) us = PULSE_MIN;
      return us[10:0];
   endfunction

   // Advances the controller by one sample and returns the motor outputs.
   function automatic motor_out_type predict_mixer(input sample_type s);
      motor_out_type o;
      longint roll_m, pitch_m, roll_dev, pitch_dev, yaw_dev, d_roll, d_pitch;
      longint base, yaw_term, pitch_term, roll_term;
      o.pulse = {4{IDLE_PULSE}};
      if (!halted) begin
         roll_m    = longint'($signed(s.roll_meas));
         pitch_m   = longint'($signed(s.pitch_meas));
         roll_dev  = roll_m - longint'($signed(s.roll_tgt));
         pitch_dev = pitch_m - longint'($signed(s.pitch_tgt));
         yaw_dev   = longint'($signed(s.yaw_meas)) - longint'($signed(s.yaw_tgt));
         d_roll    = roll_m - prev_roll;
         d_pitch   = pitch_m - prev_pitch;
         prev_roll  = roll_m;
         prev_pitch = pitch_m;
         roll_isum  = integrate(roll_isum, gain[qpmm_pkg::REG_ROLL_I], roll_dev);
         pitch_isum = integrate(pitch_isum, gain[qpmm_pkg::REG_PITCH_I], pitch_dev);
         yaw_isum   = integrate(yaw_isum, gain[qpmm_pkg::REG_YAW_I], yaw_dev);

         // Mixer terms in signed Q.24
         base       = longint'(s.thrust) <<< 24;
         yaw_term   = yaw_dev * gain[qpmm_pkg::REG_YAW_P] * 65536
                      + ((yaw_isum * gain[qpmm_pkg::REG_YAW_I]) >>> 24);
         pitch_term = (d_pitch * gain[qpmm_pkg::REG_PITCH_D]
                       + pitch_dev * gain[qpmm_pkg::REG_PITCH_P]) * 65536 + pitch_isum;
         roll_term  = (d_roll * gain[qpmm_pkg::REG_ROLL_D]
                       + roll_dev * gain[qpmm_pkg::REG_ROLL_P]) * 65536 + roll_isum;

         // Command first, then the tilt test; a halt always disarms.
         case (s.cmd)
            qpmm_pkg::CMD_STOP:   halted = 1'b1;
            qpmm_pkg::CMD_DISARM: armed = 1'b0;
            qpmm_pkg::CMD_ARM:    armed = 1'b1;
            default:              ;
         endcase
         if (roll_m > TILT_Q88 || roll_m < -TILT_Q88 ||
             pitch_m > TILT_Q88 || pitch_m < -TILT_Q88)
            halted = 1'b1;
         if (halted) armed = 1'b0;

         if (armed) begin
            o.pulse[qpmm_pkg::MOTOR_FRONT] = to_pulse(base - yaw_term - pitch_term);
            o.pulse[qpmm_pkg::MOTOR_BACK]  = to_pulse(base - yaw_term + pitch_term);
            o.pulse[qpmm_pkg::MOTOR_LEFT]  = to_pulse(base + yaw_term - roll_term);
            o.pulse[qpmm_pkg::MOTOR_RIGHT] = to_pulse(base + yaw_term + roll_term);
         end
      end
      o.armed  = armed;
      o.halted = halted;
      return o;
   endfunction

   function automatic sample_type flight_sample(input qpmm_pkg::cmd_type cmd,
                                                input int thrust,
                                                input int rt, input int pt, input int yt,
                                                input int rm, input int pm, input int ym);
      sample_type s;
      s.cmd        = cmd;
      s.thrust     = 11'(thrust);
      s.roll_tgt   = 16'(rt);
      s.pitch_tgt  = 16'(pt);
      s.yaw_tgt    = 16'(yt);
      s.roll_meas  = 16'(rm);
      s.pitch_meas = 16'(pm);
      s.yaw_meas   = 16'(ym);
      return s;
   endfunction

   // Mostly a slow drift of the attitude, sometimes a jump; never past the tilt limit.
   function automatic int walk_angle(input int a);
      int next;
      if ($urandom_range(0, 9) < 7) next = a + int'($urandom_range(0, 128)) - 64;
      else next = int'($urandom_range(0, 2 * TILT_Q88)) - TILT_Q88;
      if (next > TILT_Q88) next = TILT_Q88;
      if (next < -TILT_Q88) next = -TILT_Q88;
      return next;
   endfunction

   // Sends one sample in bursts with random gaps, and records its prediction.
   task automatic send_sample(input sample_type s);
      motor_out_type predicted;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= s.cmd;
      req_tdata  <= {5'd0, s.yaw_meas, s.pitch_meas, s.roll_meas,
                     s.yaw_tgt, s.pitch_tgt, s.roll_tgt, s.thrust};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_mixer(s);
      expected_pulses.push_back(predicted);
      sample_count++;
      if (predicted.armed) armed_count++;
   endtask

   // Holds the input side until every outstanding result has been taken.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_pulses.size() != 0);
   endtask

   // Writes all eight gain registers while the block is idle.
   task automatic apply_gains(input logic [31:0] plan [8]);
      wait_for_results();
      for (int r = 0; r < 8; r++) begin
         csr_valid <= 1'b1;
         csr_index <= r[2:0];
         csr_data  <= plan[r];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         // The proportional and derivative gains keep only their low 16 bits.
         if (r == qpmm_pkg::REG_PITCH_I || r == qpmm_pkg::REG_ROLL_I ||
             r == qpmm_pkg::REG_YAW_I)
            gain[r] = longint'(plan[r]);
         else
            gain[r] = longint'(plan[r][15:0]);
      end
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   // Reset gains: idle pulses while disarmed, thrust limits, tilt limit and setpoint range.
   task automatic test_default_gains();
      send_sample(flight_sample(qpmm_pkg::CMD_NONE, 1500, 0, 0, 0, 0, 0, 0));
      send_sample(flight_sample(qpmm_pkg::CMD_ARM, 1500, 0, 0, 0, 0, 0, 0));
      send_sample(flight_sample(qpmm_pkg::CMD_NONE, 0, 0, 0, 0, 0, 0, 0));
      send_sample(flight_sample(qpmm_pkg::CMD_NONE, 2000, 0, 0, 0, 0, 0, 0));
      // Exactly at the tilt limit on both axes, which must not halt.
      send_sample(flight_sample(qpmm_pkg::CMD_NONE, 1300, 0, 0, 0, TILT_Q88, -TILT_Q88, 0));
      send_sample(flight_sample(qpmm_pkg::CMD_NONE, 1300, 0, 0, 0, -TILT_Q88, TILT_Q88, 0));
      send_sample(flight_sample(qpmm_pkg::CMD_NONE, 1350, -32768, 32767, -32768,
                                0, 0, 32767));
      send_sample(flight_sample(qpmm_pkg::CMD_NONE, 1350, 32767, -32768, 32767,
                                0, 0, -32768));
      send_sample(flight_sample(qpmm_pkg::CMD_DISARM, 1500, 256, -256, 0, 128, -128, 64));
      send_sample(flight_sample(qpmm_pkg::CMD_NONE, 1500, 0, 0, 0, 0, 0, 0));
      send_sample(flight_sample(qpmm_pkg::CMD_ARM, 1450, 0, 0, 0, 0, 0, 0));
   endtask

   // All gains zero, then all gains at their maximum.
   task automatic test_gain_extremes();
      logic [31:0] plan [8];
      int thrust_edges [8] = '{0, 999, 1000, 1001, 1699, 1700, 1701, 2000};
      foreach (plan[r]) plan[r] = 32'd0;
      apply_gains(plan);
      send_sample(flight_sample(qpmm_pkg::CMD_ARM, thrust_edges[0], 0, 0, 0, 0, 0, 0));
      for (int k = 1; k < 8; k++)
         send_sample(flight_sample(qpmm_pkg::CMD_NONE, thrust_edges[k], 0, 0, 0, 0, 0, 0));

      // Every integral saturates at once in both directions.
      foreach (plan[r]) plan[r] = 32'hFFFF_FFFF;
      apply_gains(plan);
      send_sample(flight_sample(qpmm_pkg::CMD_NONE, 1350, 0, 0, 0, 4096, -4096, 100));
      send_sample(flight_sample(qpmm_pkg::CMD_NONE, 1350, 0, 0, 0, -4096, 4096, -100));
      send_sample(flight_sample(qpmm_pkg::CMD_NONE, 1350, 32767, -32768, 32767,
                                0, 0, -32768));
      send_sample(flight_sample(qpmm_pkg::CMD_NONE, 1350, -32768, 32767, -32768,
                                0, 0, 32767));
   endtask

   // Flights under many gain settings: drifting attitude, setpoints near or far.
   task automatic test_random_flight();
      logic [31:0] plan [8];
      int      roll_att, pitch_att, yaw_rate, pick, thrust;
      bit      wide;
      int      roll_tgt, pitch_tgt, yaw_tgt;
      qpmm_pkg::cmd_type cmd;
      for (int phase = 0; phase < FLIGHT_PHASES; phase++) begin
         for (int r = 0; r < 8; r++) begin
            wide = (r == qpmm_pkg::REG_PITCH_I || r == qpmm_pkg::REG_ROLL_I ||
                    r == qpmm_pkg::REG_YAW_I);
            // The first setting is gentle and the second the reset one.
            pick = (phase == 0) ? 3 : (phase == 1) ? 2 : $urandom_range(0, 4);
            case (pick)
               0: plan[r] = 32'd0;
               1: plan[r] = 32'hFFFF_FFFF;
               2: plan[r] = default_gain(r);
               3: plan[r] = wide ? $urandom_range(0, 1 << 20) : $urandom_range(0, 40);
               default: plan[r] = $urandom();
            endcase
         end
         apply_gains(plan);

         roll_att  = walk_angle(0);
         pitch_att = walk_angle(0);
         for (int n = 0; n < FLIGHT_SAMPLES; n++) begin
            roll_att  = walk_angle(roll_att);
            pitch_att = walk_angle(pitch_att);
            pick = $urandom_range(0, 99);
            cmd = (n == 0 || pick < 8) ? qpmm_pkg::CMD_ARM :
                  (pick < 12) ? qpmm_pkg::CMD_DISARM : qpmm_pkg::CMD_NONE;
            thrust = ($urandom_range(0, 4) != 0) ? $urandom_range(900, 1800)
                                                 : $urandom_range(0, 2000);
            yaw_rate = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 1024)) - 512
                                                   : int'($urandom_range(0, 65535));
            if ($urandom_range(0, 9) < 6) begin
               roll_tgt  = roll_att + int'($urandom_range(0, 256)) - 128;
               pitch_tgt = pitch_att + int'($urandom_range(0, 256)) - 128;
               yaw_tgt   = yaw_rate + int'($urandom_range(0, 256)) - 128;
            end else begin
               roll_tgt  = $urandom_range(0, 65535);
               pitch_tgt = $urandom_range(0, 65535);
               yaw_tgt   = $urandom_range(0, 65535);
            end
            send_sample(flight_sample(cmd, thrust, roll_tgt, pitch_tgt, yaw_tgt,
                                      roll_att, pitch_att, yaw_rate));
         end
      end
   endtask

   // Enters the halt latch once, then checks that nothing moves it any more.
   task automatic test_halt_latch();
      sample_type s;
      wait_for_results();
      send_sample(flight_sample(qpmm_pkg::CMD_ARM, 1400, 0, 0, 0, 256, -256, 0));
      case ($urandom_range(0, 5))
         0, 1, 2: begin
            halt_cause = "the stop command";
            s = flight_sample(qpmm_pkg::CMD_STOP, 1400, 0, 0, 0, 256, -256, 0);
         end
         3: begin
            halt_cause = "a roll just past the tilt limit";
            s = flight_sample(qpmm_pkg::CMD_ARM, 1400, 0, 0, 0, TILT_Q88 + 1, 0, 0);
         end
         4: begin
            halt_cause = "a pitch just past the negative tilt limit";
            s = flight_sample(qpmm_pkg::CMD_NONE, 1400, 0, 0, 0, 0, -TILT_Q88 - 1, 0);
         end
         default: begin
            halt_cause = "full-scale roll and pitch";
            s = flight_sample(qpmm_pkg::CMD_NONE, 1400, 0, 0, 0, -32768, 32767, 0);
         end
      endcase
      send_sample(s);
      repeat (HALTED_SAMPLES) begin
         s = flight_sample(qpmm_pkg::cmd_type'($urandom_range(0, 3)),
                           $urandom_range(0, 2000),
                           $urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(0, 65535));
         send_sample(s);
      end
   endtask

   // Result side stalls in phases: always ready, random, sparse, or alternating.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_mode <= 0;
         ready_left <= 0;
      end else if (ready_left == 0) begin
         ready_mode <= $urandom_range(0, 3);
         ready_left <= $urandom_range(16, 160);
         rsp_tready <= 1'b1;
      end else begin
         ready_left <= ready_left - 1;
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 9) == 0);
            default: rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   // Each result transfer is compared with the oldest prediction.
   always @(posedge clock) begin : check_results
      motor_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pulses.size() == 0) begin
            $error("Result with nothing expected: tdata %h tuser %b", rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want = expected_pulses.pop_front();
            for (int m = 0; m < 4; m++) begin
               if (rsp_tdata[m*11 +: 11] !== want.pulse[m]) begin
                  $error("%s: expected %0d, got %0d", motor_name[m], want.pulse[m],
                         rsp_tdata[m*11 +: 11]);
                  fail_count++;
               end
            end
            if (rsp_tuser[0] !== want.armed) begin
               $error("is_armed: expected %0d, got %0d", want.armed, rsp_tuser[0]);
               fail_count++;
            end
            if (rsp_tuser[1] !== want.halted) begin
               $error("is_halted: expected %0d, got %0d", want.halted, rsp_tuser[1]);
               fail_count++;
            end
         end
      end
   end

   // Ends the run when no transfer of any kind has happened for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $error("No transfer for %0d cycles, %0d results outstanding", idle_cycles,
                expected_pulses.size());
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      foreach (gain[r]) gain[r] = longint'(default_gain(r));
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_default_gains();
      test_gain_extremes();
      test_random_flight();
      test_halt_latch();

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d samples under %0d written gain settings, %0d with motors armed.",
               sample_count, setting_count, armed_count);
      $display("The halt latch was entered by %s and held through random samples.",
               halt_cause);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
